/* rtl/uvcpfa_pkg.sv */
// Shared types and constants of the UVC payload frame assembler.
`timescale 1ns / 1ps

package uvcpfa_pkg;

   localparam int DEF_RING_SLOTS     = 2;
   localparam int DEF_MAX_PACKET     = 4096;
   localparam int DEF_FRAME_CAPACITY = 4194304;

   localparam logic [22:0] FRAME_SIZE_RESET = 23'd614400;

   // payload header flag bits (byte 1 of a packet)
   localparam int FLAG_FID = 0;
   localparam int FLAG_EOF = 1;
   localparam int FLAG_ERR = 6;

   localparam logic       KIND_WRITE    = 1'b0;
   localparam logic       KIND_COMPLETE = 1'b1;

   // register indexes on the configuration port
   localparam logic       CSR_FRAME_SIZE = 1'b0;

   localparam logic [1:0] FID_NONE = 2'd2;

   // result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [7:0]  packet_byte;
      logic [12:0] packet_length;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic        slot;
      logic [21:0] write_offset;
      logic [7:0]  write_byte;
      logic [22:0] frame_length;
      logic        frame_bad;
      logic [31:0] frame_sequence;
      logic        last;
   } rsp_type;

   // results caused by one accepted byte, first one in r0
   typedef struct packed {
      logic [1:0] count;
      rsp_type    r0;
      rsp_type    r1;
   } push_type;

endpackage

/* rtl/uvc_payload_frame_assembler.sv */
// Top level of the UVC payload frame assembler: register port, byte core, result queue.
`timescale 1ns / 1ps

// Takes one isochronous packet byte per clock cycle and checks the payload
// header; payload bytes become write results (slot, offset, byte) and
// the last byte of an end-of-frame packet also yields a frame-complete result.
// A byte is processed in the cycle it is transferred and its results land in a
// four-entry result queue; req_stall rises while that queue holds more than two
// results, so a byte is taken every cycle as long as results drain at one per
// cycle (a byte that ends a frame may add two). frame_size sits at byte address 0.

module uvc_payload_frame_assembler #(
   parameter int RING_SLOTS     = uvcpfa_pkg::DEF_RING_SLOTS,
   parameter int MAX_PACKET     = uvcpfa_pkg::DEF_MAX_PACKET,
   parameter int FRAME_CAPACITY = uvcpfa_pkg::DEF_FRAME_CAPACITY
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  uvcpfa_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output uvcpfa_pkg::rsp_type rsp_data,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   logic [22:0]          frame_size_ff;
   logic                 accept, full, hit;
   uvcpfa_pkg::push_type push;

   assign pready    = 1'b1;
   assign req_stall = full;
   assign accept    = req_valid && !full;
   assign hit       = paddr[2] == uvcpfa_pkg::CSR_FRAME_SIZE;
   assign prdata    = hit ? {9'd0, frame_size_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_size_ff <= uvcpfa_pkg::FRAME_SIZE_RESET;
      end else if (psel && penable && pwrite && pready && hit) begin
         frame_size_ff <= pwdata[22:0];
      end
   end

   uvcpfa_core #(
      .RING_SLOTS     (RING_SLOTS),
      .MAX_PACKET     (MAX_PACKET),
      .FRAME_CAPACITY (FRAME_CAPACITY)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .frame_size (frame_size_ff),
      .push       (push)
   );

   uvcpfa_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* rtl/uvcpfa_core.sv */
// Header check, frame tracking and result generation for each accepted byte.
`timescale 1ns / 1ps

module uvcpfa_core #(
   parameter int RING_SLOTS     = uvcpfa_pkg::DEF_RING_SLOTS,
   parameter int MAX_PACKET     = uvcpfa_pkg::DEF_MAX_PACKET,
   parameter int FRAME_CAPACITY = uvcpfa_pkg::DEF_FRAME_CAPACITY
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  uvcpfa_pkg::req_type  req,
   input  logic [22:0]          frame_size,
   output uvcpfa_pkg::push_type push
);

   localparam int POS_W  = $clog2(MAX_PACKET);
   localparam int LEN_W  = ($clog2(MAX_PACKET + 1) > 13) ? $clog2(MAX_PACKET + 1) : 13;
   localparam int FILL_W = $clog2(FRAME_CAPACITY + 1);
   localparam int SLOT_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
   localparam int CMP_W  = (FILL_W > 23) ? FILL_W : 23;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [7:0]        hlen_ff, hlen_in;
   logic [7:0]        flags_ff, flags_in;
   logic              hvalid_ff, hvalid_in;
   logic [1:0]        prev_fid_ff, prev_fid_in;
   logic [31:0]       seq_ff, seq_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              ferr_ff, ferr_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;

   logic [LEN_W-1:0]  len_raw, len_c, pos_x;
   logic              is_last, hdr_ok, do_write, do_done, bad;
   uvcpfa_pkg::rsp_type wr_r, done_r;

   always_comb begin
      len_raw = LEN_W'(req.packet_length);
      if (len_raw == '0) begin
         len_c = LEN_W'(1);
      end else if (len_raw > LEN_W'(MAX_PACKET)) begin
         len_c = LEN_W'(MAX_PACKET);
      end else begin
         len_c = len_raw;
      end
      pos_x   = LEN_W'(pos_ff);
      is_last = LEN_W'(pos_x + LEN_W'(1)) >= len_c;
      hdr_ok  = (len_c >= LEN_W'(2)) && (hlen_ff >= 8'd2) && (LEN_W'(hlen_ff) <= len_c);

      hlen_in     = hlen_ff;
      flags_in    = flags_ff;
      hvalid_in   = hvalid_ff;
      prev_fid_in = prev_fid_ff;
      seq_in      = seq_ff;
      fill_in     = fill_ff;
      ferr_in     = ferr_ff;
      slot_in     = slot_ff;
      do_write    = 1'b0;

      if (pos_ff == '0) begin
         hlen_in   = req.packet_byte;
         flags_in  = '0;
         hvalid_in = 1'b0;
      end else if (pos_ff == POS_W'(1)) begin
         flags_in = req.packet_byte;
         if (hdr_ok) begin
            hvalid_in   = 1'b1;
            prev_fid_in = {1'b0, req.packet_byte[uvcpfa_pkg::FLAG_FID]};
            if (prev_fid_ff != {1'b0, req.packet_byte[uvcpfa_pkg::FLAG_FID]}) begin
               seq_in = seq_ff + 32'd1;
            end
            if (req.packet_byte[uvcpfa_pkg::FLAG_ERR]) begin
               ferr_in = 1'b1;
            end
         end
      end else if (hvalid_ff && pos_x >= LEN_W'(hlen_ff)) begin
         if (fill_ff < FILL_W'(FRAME_CAPACITY)) begin
            do_write = 1'b1;
            fill_in  = fill_ff + FILL_W'(1);
         end else begin
            ferr_in = 1'b1;
         end
      end

      // completion sees the values left by this byte
      do_done = is_last && hvalid_in && (pos_ff != '0) && flags_in[uvcpfa_pkg::FLAG_EOF];
      bad     = ferr_in || (CMP_W'(fill_in) != CMP_W'(frame_size));

      wr_r                = '0;
      wr_r.kind           = uvcpfa_pkg::KIND_WRITE;
      wr_r.slot           = slot_ff[0];
      wr_r.write_offset   = 22'(fill_ff);
      wr_r.write_byte     = req.packet_byte;
      wr_r.last           = !do_done;

      done_r                = '0;
      done_r.kind           = uvcpfa_pkg::KIND_COMPLETE;
      done_r.slot           = slot_ff[0];
      done_r.frame_length   = 23'(fill_in);
      done_r.frame_bad      = bad;
      done_r.frame_sequence = seq_in;
      done_r.last           = 1'b1;

      if (do_done) begin
         fill_in = '0;
         ferr_in = 1'b0;
         if (slot_ff == SLOT_W'(RING_SLOTS - 1)) begin
            slot_in = '0;
         end else begin
            slot_in = slot_ff + SLOT_W'(1);
         end
      end

      if (is_last) begin
         pos_in    = '0;
         hvalid_in = 1'b0;
      end else begin
         pos_in = POS_W'(pos_x + LEN_W'(1));
      end

      push = '0;
      if (accept) begin
         if (do_write) begin
            push.r0    = wr_r;
            push.r1    = done_r;
            push.count = do_done ? 2'd2 : 2'd1;
         end else if (do_done) begin
            push.r0    = done_r;
            push.count = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         hlen_ff     <= '0;
         flags_ff    <= '0;
         hvalid_ff   <= 1'b0;
         prev_fid_ff <= uvcpfa_pkg::FID_NONE;
         seq_ff      <= '1;
         fill_ff     <= '0;
         ferr_ff     <= 1'b0;
         slot_ff     <= '0;
      end else if (accept) begin
         pos_ff      <= pos_in;
         hlen_ff     <= hlen_in;
         flags_ff    <= flags_in;
         hvalid_ff   <= hvalid_in;
         prev_fid_ff <= prev_fid_in;
         seq_ff      <= seq_in;
         fill_ff     <= fill_in;
         ferr_ff     <= ferr_in;
         slot_ff     <= slot_in;
      end
   end

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd2 |-> push.r0.kind == uvcpfa_pkg::KIND_WRITE && !push.r0.last
                             && push.r1.kind == uvcpfa_pkg::KIND_COMPLETE && push.r1.last)
      else $error("two results must be a write followed by a completion");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      push.count == 2'd1 |-> push.r0.last)
      else $error("single result not marked last");

   a_done_clears_fill: assert property (@(posedge clock) disable iff (reset)
      accept && do_done |=> fill_ff == '0 && !ferr_ff)
      else $error("frame state not cleared after completion");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(FRAME_CAPACITY))
      else $error("fill offset beyond capacity");

endmodule

/* rtl/uvcpfa_fifo.sv */
// Result queue: takes up to two results a cycle, hands out one per transfer.
`timescale 1ns / 1ps

module uvcpfa_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  uvcpfa_pkg::push_type push,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output uvcpfa_pkg::rsp_type  rsp_data
);

   localparam int AW = uvcpfa_pkg::FIFO_AW;
   localparam int CW = uvcpfa_pkg::FIFO_CW;

   uvcpfa_pkg::rsp_type mem_ff [uvcpfa_pkg::FIFO_DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          pop;

   assign rsp_valid = cnt_ff != '0;
   assign rsp_data  = mem_ff[rd_ff];
   assign pop       = rsp_valid && !rsp_stall;
   // room for a pair is required before a byte is taken
   assign full      = cnt_ff > CW'(uvcpfa_pkg::FIFO_DEPTH - 2);

   always_comb begin
      wr_in  = wr_ff + AW'(push.count);
      rd_in  = pop ? rd_ff + AW'(1) : rd_ff;
      cnt_in = cnt_ff + CW'(push.count) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.r0;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ff + AW'(1)] <= push.r1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      push.count != 2'd0 |-> cnt_ff <= CW'(uvcpfa_pkg::FIFO_DEPTH - 2))
      else $error("push into queue without room");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(uvcpfa_pkg::FIFO_DEPTH))
      else $error("queue count out of range");

endmodule

/* verif/tb_uvc_payload_frame_assembler.sv */
// Testbench for the UVC payload frame assembler: packet streams checked against a byte predictor.
`timescale 1ns / 1ps

module tb_uvc_payload_frame_assembler;

   localparam logic [7:0] F_FID = 8'(1 << uvcpfa_pkg::FLAG_FID);
   localparam logic [7:0] F_EOF = 8'(1 << uvcpfa_pkg::FLAG_EOF);
   localparam logic [7:0] F_ERR = 8'(1 << uvcpfa_pkg::FLAG_ERR);

   localparam int IDLE_NONE   = 0;
   localparam int IDLE_FULL   = 1;
   localparam int IDLE_SPARSE = 2;

   logic                sclock = 1'b0;
   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   uvcpfa_pkg::req_type req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   uvcpfa_pkg::rsp_type rsp_data;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [2:0]          paddr = '0;
   logic [31:0]         pwdata = '0;
   logic [31:0]         prdata;
   logic                pready;

   // predictor state
   logic [22:0] cfg_frame_size = uvcpfa_pkg::FRAME_SIZE_RESET;
   int unsigned pkt_pos = 0;
   logic [7:0]  hdr_len = '0;
   logic [7:0]  hdr_flags = '0;
   bit          hdr_good = 1'b0;
   logic [1:0]  seen_fid = uvcpfa_pkg::FID_NONE;
   logic [31:0] frame_seq = '1;
   int unsigned fill_count = 0;
   bit          frame_err = 1'b0;
   int unsigned ring_slot = 0;

   uvcpfa_pkg::rsp_type pending_results[$];
   uvcpfa_pkg::rsp_type want;
   int          errors = 0;
   int          req_idle_mode = IDLE_NONE;
   int          rsp_idle_mode = IDLE_NONE;
   int          rsp_hold = 0;

   assign clock = sclock;

   uvc_payload_frame_assembler u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always #4 sclock = ~sclock;

   function automatic int draw_idle(input int mode);
      case (mode)
         IDLE_NONE: return 0;
         IDLE_FULL: return $urandom_range(0, 19);
         default:   return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 19) : 0;
      endcase
   endfunction

   // Works out the writes and frame completion caused by one transferred byte.
   function automatic void predict_byte_results(input uvcpfa_pkg::req_type item);
      int unsigned         len;
      bit                  at_end;
      uvcpfa_pkg::rsp_type res[$];
      uvcpfa_pkg::rsp_type r;
      logic [1:0]          fid;
      len = item.packet_length;
      if (len == 0) len = 1;
      if (len > uvcpfa_pkg::DEF_MAX_PACKET) len = uvcpfa_pkg::DEF_MAX_PACKET;
      at_end = (pkt_pos + 1 >= len);

      if (pkt_pos == 0) begin
         hdr_len = item.packet_byte;
         hdr_flags = '0;
         hdr_good = 1'b0;
      end else if (pkt_pos == 1) begin
         hdr_flags = item.packet_byte;
         if (len >= 2 && hdr_len >= 2 && hdr_len <= len) begin
            hdr_good = 1'b1;
            fid = {1'b0, item.packet_byte[uvcpfa_pkg::FLAG_FID]};
            if (seen_fid != fid) frame_seq = frame_seq + 1;
            if (item.packet_byte[uvcpfa_pkg::FLAG_ERR]) frame_err = 1'b1;
            seen_fid = fid;
         end
      end else if (hdr_good && pkt_pos >= hdr_len) begin
         if (fill_count < uvcpfa_pkg::DEF_FRAME_CAPACITY) begin
            r = '0;
            r.kind = uvcpfa_pkg::KIND_WRITE;
            r.slot = ring_slot[0];
            r.write_offset = fill_count[21:0];
            r.write_byte = item.packet_byte;
            res.push_back(r);
            fill_count++;
         end else begin
            frame_err = 1'b1;
         end
      end

      if (at_end) begin
         if (hdr_good && pkt_pos >= 1 && hdr_flags[uvcpfa_pkg::FLAG_EOF]) begin
            r = '0;
            r.kind = uvcpfa_pkg::KIND_COMPLETE;
            r.slot = ring_slot[0];
            r.frame_length = fill_count[22:0];
            r.frame_bad = frame_err || (fill_count != cfg_frame_size);
            r.frame_sequence = frame_seq;
            res.push_back(r);
            fill_count = 0;
            frame_err = 1'b0;
            ring_slot = (ring_slot + 1) % uvcpfa_pkg::DEF_RING_SLOTS;
         end
         pkt_pos = 0;
         hdr_good = 1'b0;
      end else begin
         pkt_pos++;
      end

      if (res.size() > 0) res[res.size() - 1].last = 1'b1;
      foreach (res[i]) pending_results.push_back(res[i]);
   endfunction

   // Predicts on byte transfers, then checks result transfers in the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) predict_byte_results(req_data);
         if (rsp_valid && !rsp_stall) begin
            rsp_hold = draw_idle(rsp_idle_mode);
            if (pending_results.size() == 0) begin
               $error("unexpected result transfer: %p", rsp_data);
               errors++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.kind !== want.kind) begin
                  $error("kind: expected %0d, got %0d", want.kind, rsp_data.kind);
                  errors++;
               end
               if (rsp_data.slot !== want.slot) begin
                  $error("slot: expected %0d, got %0d", want.slot, rsp_data.slot);
                  errors++;
               end
               if (rsp_data.write_offset !== want.write_offset) begin
                  $error("write_offset: expected %0d, got %0d",
                         want.write_offset, rsp_data.write_offset);
                  errors++;
               end
               if (rsp_data.write_byte !== want.write_byte) begin
                  $error("write_byte: expected %0h, got %0h",
                         want.write_byte, rsp_data.write_byte);
                  errors++;
               end
               if (rsp_data.frame_length !== want.frame_length) begin
                  $error("frame_length: expected %0d, got %0d",
                         want.frame_length, rsp_data.frame_length);
                  errors++;
               end
               if (rsp_data.frame_bad !== want.frame_bad) begin
                  $error("frame_bad: expected %0d, got %0d", want.frame_bad, rsp_data.frame_bad);
                  errors++;
               end
               if (rsp_data.frame_sequence !== want.frame_sequence) begin
                  $error("frame_sequence: expected %0d, got %0d",
                         want.frame_sequence, rsp_data.frame_sequence);
                  errors++;
               end
               if (rsp_data.last !== want.last) begin
                  $error("last: expected %0d, got %0d", want.last, rsp_data.last);
                  errors++;
               end
            end
         end
      end
   end

   // result-side back-pressure: hold stall for the drawn number of cycles per transfer
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         rsp_hold--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // called and returns at a falling edge
   task automatic send_byte(input logic [7:0] value, input logic [12:0] length);
      int gap;
      gap = draw_idle(req_idle_mode);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= {value, length};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_packet(input int total, input logic [7:0] hlen, input logic [7:0] flags);
      for (int i = 0; i < total; i++)
         send_byte(i == 0 ? hlen : (i == 1 ? flags : 8'($urandom)), 13'(total));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      // bytes with no result may still be in flight
      repeat (4) @(negedge clock);
   endtask

   task automatic write_frame_size(input logic [22:0] value);
      wait_drained();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {uvcpfa_pkg::CSR_FRAME_SIZE, 2'b00};
      pwdata <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      cfg_frame_size = value;
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // two packets that add up to exactly the configured frame size
   task automatic test_exact_frame();
      write_frame_size(23'd4);
      req_idle_mode = IDLE_SPARSE;
      rsp_idle_mode = IDLE_SPARSE;
      send_packet(4, 8'd2, 8'h00);
      send_packet(4, 8'd2, F_EOF);
   endtask

   task automatic test_header_cases();
      send_byte(8'd2, 13'd1);                     // one-byte packet, never ends a frame
      send_byte(8'h00, 13'd0);                    // zero length counts as one
      send_packet(3, 8'd1, F_EOF);                // header length too short
      send_packet(2, 8'hFF, 8'hFF);               // header length beyond packet
      send_packet(3, 8'd3, F_FID | F_EOF | F_ERR); // header only, error flagged, fid toggles
   endtask

   // length field changes inside a packet; oversized values clamp
   task automatic test_length_drift();
      send_byte(8'd2, 13'h1FFF);
      send_byte(F_EOF | F_FID, 13'h1FFF);
      send_byte(8'h00, 13'd4096);
      send_byte(8'hFF, 13'd4);
   endtask

   task automatic test_random_frames(input logic [22:0] size, input int target);
      int         sent;
      int         pick;
      int         total;
      int         hl;
      logic [7:0] fl;
      logic       fid;
      write_frame_size(size);
      req_idle_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
      rsp_idle_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
      sent = 0;
      fid = 1'b0;
      while (sent < target) begin
         pick = $urandom_range(0, 19);
         if (pick < 16) begin
            total = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(2, 16);
            if (total >= 12 && $urandom_range(0, 3) == 0) hl = 12;
            else hl = $urandom_range(2, total < 6 ? total : 6);
            if ($urandom_range(0, 3) == 0) fid = ~fid;
            fl = 8'($urandom);
            fl[uvcpfa_pkg::FLAG_FID] = fid;
            fl[uvcpfa_pkg::FLAG_EOF] = ($urandom_range(0, 2) == 0);
            fl[uvcpfa_pkg::FLAG_ERR] = ($urandom_range(0, 7) == 0);
            send_packet(total, 8'(hl), fl);
            sent += total;
         end else if (pick == 16) begin
            total = $urandom_range(2, 10);
            if ($urandom_range(0, 1) == 1) hl = $urandom_range(0, 1);
            else hl = $urandom_range(total + 1, 255);
            send_packet(total, 8'(hl), 8'($urandom));
         end else if (pick == 17) begin
            send_byte(8'($urandom), ($urandom_range(0, 1) == 1) ? 13'd1 : 13'd0);
         end else begin
            // length varies per byte; only the final byte claims to be the end
            total = $urandom_range(3, 8);
            for (int i = 0; i < total; i++) begin
               if (i == 0) fl = 8'($urandom_range(2, total + 3));
               else if (i == 1) fl = 8'($urandom) | (($urandom_range(0, 1) == 1) ? F_EOF : 8'h00);
               else fl = 8'($urandom);
               if (i == total - 1) send_byte(fl, 13'($urandom_range(1, total)));
               else send_byte(fl, 13'($urandom_range(total, 8191)));
            end
            sent += total;
         end
         if ($urandom_range(0, 15) == 0) begin
            req_idle_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
            rsp_idle_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_exact_frame();
      test_header_cases();
      test_length_drift();
      test_random_frames(23'd0, 95);
      test_random_frames(23'd4194304, 95);
      test_random_frames(23'd24, 95);
      test_random_frames(uvcpfa_pkg::FRAME_SIZE_RESET, 55);
      test_random_frames(23'($urandom_range(1, 40)), 95);
      test_random_frames(23'd8, 55);
      wait_drained();
      repeat (4) @(negedge clock);
      if (errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

/* files.f */
rtl/uvcpfa_pkg.sv
rtl/uvcpfa_core.sv
rtl/uvcpfa_fifo.sv
rtl/uvc_payload_frame_assembler.sv
verif/tb_uvc_payload_frame_assembler.sv
